// ----- src/byte_pattern_matcher_macros.svh -----
// Assertion macros for the byte pattern matcher.
// Both expect i_clk and i_rst_n in the scope of use.
`ifndef BYTE_PATTERN_MATCHER_MACROS_SVH
`define BYTE_PATTERN_MATCHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BPM_ASSERT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpm assertion failed");

// next-cycle implication
`define BPM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpm assertion failed");

`else

`define BPM_ASSERT(name, ante, cons)
`define BPM_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ----- src/bpm_pkg.sv -----
`default_nettype none

package bpm_pkg;

    localparam int CFG_WORDS  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int REG_BYTES  = 32;
    localparam int FAIL_POS_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD_3 = 2'd3;

    localparam logic [3:0] CMD_END     = 4'h0;
    localparam logic [3:0] CMD_LITERAL = 4'h1;
    localparam logic [3:0] CMD_REPEAT  = 4'h2;
    localparam logic [3:0] CMD_SKIP    = 4'hF;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_LITERAL = 2'd1;
    localparam logic [1:0] KIND_REPEAT  = 2'd2;
    localparam logic [1:0] KIND_SKIP    = 2'd3;

    typedef struct packed {
        logic                  matched;
        logic [FAIL_POS_W-1:0] fail_position;
    } t_result;

endpackage

`default_nettype wire

// ----- src/bpm_step.sv -----
`default_nettype none

`include "byte_pattern_matcher_macros.svh"

module bpm_step #(
    parameter int PATTERN_BYTES = 32,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_step,
    input  wire logic [7:0]                                    i_data,
    input  wire logic                                          i_last,
    input  wire logic [bpm_pkg::REG_BYTES*8-1:0]               i_pattern,
    output bpm_pkg::t_result                                   o_result
);
    import bpm_pkg::*;

    localparam int PTR_W = $clog2(PATTERN_BYTES + 1);
    localparam int RD_W  = PTR_W + 1;
    localparam int LIMIT = (PATTERN_BYTES < REG_BYTES) ? PATTERN_BYTES : REG_BYTES;
    localparam int EXT_W = (POSITION_BITS > FAIL_POS_W) ? POSITION_BITS : FAIL_POS_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [PTR_W-1:0]         r_ptr;
    logic [4:0]               r_rem;
    logic [1:0]               r_kind;
    logic [POSITION_BITS-1:0] r_cnt;
    logic                     r_failed;
    logic [POSITION_BITS-1:0] r_ffpos;

    logic [7:0]               pat_b [REG_BYTES];
    logic [POSITION_BITS-1:0] pos;
    logic [POSITION_BITS-1:0] pos_nxt;
    logic [RD_W-1:0]          rd0;
    logic [RD_W-1:0]          rd1;
    logic [RD_W-1:0]          rd2;
    logic [7:0]               b0;
    logic [7:0]               b1;
    logic [7:0]               b2;
    logic [7:0]               cur;
    logic [7:0]               end_b;
    logic [1:0]               cmd_kind;
    logic                     fetch;
    logic                     fail_cmd;
    logic                     take;
    logic                     mismatch;
    logic                     fail_data;
    logic                     end_fail;
    logic [1:0]               kind_a;
    logic [1:0]               n_kind;
    logic [4:0]               rem_a;
    logic [4:0]               n_rem;
    logic [PTR_W-1:0]         ptr_a;
    logic [PTR_W-1:0]         n_ptr;
    logic [1:0]               off;
    logic [POSITION_BITS-1:0] fpos;
    logic [EXT_W-1:0]         fpos_ext;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p < PTR_W'(PATTERN_BYTES)) ? p + PTR_W'(1) : p;
    endfunction

    always_comb begin
        for (int k = 0; k < REG_BYTES; k++) begin
            pat_b[k] = i_pattern[8*k +: 8];
        end
    end

    always_comb begin
        pos     = (r_cnt == POS_MAX) ? r_cnt : r_cnt + POSITION_BITS'(1);
        pos_nxt = (pos == POS_MAX) ? pos : pos + POSITION_BITS'(1);

        rd0 = RD_W'(r_ptr);
        rd1 = RD_W'(r_ptr) + RD_W'(1);
        rd2 = RD_W'(r_ptr) + RD_W'(2);
        b0  = (rd0 < RD_W'(LIMIT)) ? pat_b[rd0[4:0]] : 8'h00;
        b1  = (rd1 < RD_W'(LIMIT)) ? pat_b[rd1[4:0]] : 8'h00;
        b2  = (rd2 < RD_W'(LIMIT)) ? pat_b[rd2[4:0]] : 8'h00;

        case (b0[3:0])
            CMD_LITERAL: cmd_kind = KIND_LITERAL;
            CMD_REPEAT:  cmd_kind = KIND_REPEAT;
            CMD_SKIP:    cmd_kind = KIND_SKIP;
            default:     cmd_kind = KIND_NONE;
        endcase

        fetch    = !r_failed && (r_rem == 5'd0);
        fail_cmd = fetch && (cmd_kind == KIND_NONE);
        take     = fetch && !fail_cmd;

        kind_a = take ? cmd_kind : r_kind;
        rem_a  = take ? ({1'b0, b0[7:4]} + 5'd1) : r_rem;
        ptr_a  = take ? adv(r_ptr) : r_ptr;
        off    = take ? 2'd1 : 2'd0;
        cur    = take ? b1 : b0;

        mismatch = 1'b0;
        n_ptr    = ptr_a;
        n_rem    = rem_a - 5'd1;
        if (!r_failed && !fail_cmd) begin
            case (kind_a)
                KIND_LITERAL: begin
                    if (i_data != cur) begin
                        mismatch = 1'b1;
                    end else begin
                        n_ptr = adv(ptr_a);
                        off   = off + 2'd1;
                    end
                end
                KIND_REPEAT: begin
                    if (i_data != cur) begin
                        mismatch = 1'b1;
                    end else if (n_rem == 5'd0) begin
                        n_ptr = adv(ptr_a);
                        off   = off + 2'd1;
                    end
                end
                default: ;
            endcase
        end
        n_kind    = (n_rem == 5'd0) ? KIND_NONE : kind_a;
        fail_data = fail_cmd || mismatch;

        case (off)
            2'd0:    end_b = b0;
            2'd1:    end_b = b1;
            default: end_b = b2;
        endcase

        // packet ended with a command still running or pattern not at its end
        end_fail = !r_failed && !fail_data &&
                   ((n_rem != 5'd0) || (end_b[3:0] != CMD_END));

        if (r_failed) begin
            fpos = r_ffpos;
        end else if (fail_data) begin
            fpos = pos;
        end else if (end_fail) begin
            fpos = pos_nxt;
        end else begin
            fpos = '0;
        end
        fpos_ext = EXT_W'(fpos);

        o_result.matched       = !(r_failed || fail_data || end_fail);
        o_result.fail_position = fpos_ext[FAIL_POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_rem    <= '0;
            r_kind   <= KIND_NONE;
            r_cnt    <= '0;
            r_failed <= 1'b0;
            r_ffpos  <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_ptr    <= '0;
                r_rem    <= '0;
                r_kind   <= KIND_NONE;
                r_cnt    <= '0;
                r_failed <= 1'b0;
                r_ffpos  <= '0;
            end else begin
                r_cnt <= pos;
                if (!r_failed) begin
                    if (fail_data) begin
                        r_failed <= 1'b1;
                        r_ffpos  <= pos;
                    end else begin
                        r_ptr  <= n_ptr;
                        r_rem  <= n_rem;
                        r_kind <= n_kind;
                    end
                end
            end
        end
    end

    `BPM_ASSERT(a_kind_tracks_run, !r_failed, (r_kind == KIND_NONE) == (r_rem == 5'd0))
    `BPM_ASSERT(a_fail_pos_set, r_failed, r_ffpos != '0)
    `BPM_ASSERT(a_ptr_bound, 1'b1, r_ptr <= PTR_W'(PATTERN_BYTES))
    `BPM_ASSERT_NEXT(a_packet_clear, i_step && i_last, (r_cnt == '0) && !r_failed)

endmodule

`default_nettype wire

// ----- src/byte_pattern_matcher.sv -----
`default_nettype none

// Channel   Dir  Payload                                   Transfer
// s_axis    in   tdata[7:0] data_byte, tlast last_byte      tvalid & tready
// m_axis    out  tdata[0] matched, [16:1] fail_position     tvalid & tready
// cfg       in   i_cfg_index register, i_cfg_data value     i_cfg_valid & o_cfg_ready
//
// One byte per cycle sustained unless m_axis holds a last byte; a byte goes
// input register -> matcher logic -> result register, which drives m_axis_tvalid.
// The pattern check is a nibble decode plus one byte compare per cycle.
// Reset (i_rst_n low, synchronous) clears pattern words and match state.
// A stalled m_axis holds only a last byte in the input register; other bytes flow.

module byte_pattern_matcher #(
    parameter int PATTERN_BYTES = 32,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  wire logic                            s_axis_tlast,
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [23:0]                     m_axis_tdata,  // [0] matched, [16:1] fail_position
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [bpm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bpm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bpm_pkg::*;

    logic [CFG_DATA_W-1:0]    r_pat [CFG_WORDS];
    logic [REG_BYTES*8-1:0]   pattern;
    logic                     r_in_valid;
    logic [7:0]               r_in_data;
    logic                     r_in_last;
    logic                     r_out_valid;
    t_result                  r_out;
    t_result                  result;
    logic                     out_free;
    logic                     step;

    assign o_cfg_ready = 1'b1;
    assign pattern     = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_WORDS; k++) begin
                r_pat[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PAT_WORD_0: r_pat[0] <= i_cfg_data;
                CFG_PAT_WORD_1: r_pat[1] <= i_cfg_data;
                CFG_PAT_WORD_2: r_pat[2] <= i_cfg_data;
                CFG_PAT_WORD_3: r_pat[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    bpm_step #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_data    (r_in_data),
        .i_last    (r_in_last),
        .i_pattern (pattern),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.fail_position, r_out.matched};

endmodule

`default_nettype wire

// ----- tb/tb_byte_pattern_matcher.sv -----
module tb_byte_pattern_matcher;
    import bpm_pkg::*;

    localparam int PATTERN_BYTES = 32;
    localparam int POSITION_BITS = 16;
    localparam int MAX_PKT_LEN   = 96;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] data_byte
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;   // [0] matched, [16:1] fail_position
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    byte_pattern_matcher #(
        .PATTERN_BYTES(PATTERN_BYTES),
        .POSITION_BITS(POSITION_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // matcher model state
    logic [CFG_DATA_W-1:0] pat_words [CFG_WORDS];
    logic [5:0]            pat_ptr;
    logic [4:0]            run_left;
    logic [1:0]            run_kind;
    logic [15:0]           byte_count;
    logic                  pkt_failed;
    logic [15:0]           first_fail_pos;

    t_result               pending_verdicts [$];
    logic [7:0]            pat_draft [REG_BYTES];
    logic [7:0]            pkt_bytes [$];
    int                    err_count = 0;
    int                    bytes_sent = 0;
    bit                    idle_on = 1'b1;
    bit                    rx_hold_req = 1'b0;
    int                    rx_gap = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // receiver: random short stalls, or a long hold when requested
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_gap <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, got matched %0b fail_position %0d",
                         $time, m_axis_tdata[0], m_axis_tdata[16:1]);
                err_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.matched) begin
                    $display("%0t: matched expected %0b got %0b",
                             $time, want.matched, m_axis_tdata[0]);
                    err_count++;
                end
                if (m_axis_tdata[16:1] !== want.fail_position) begin
                    $display("%0t: fail_position expected %0d got %0d",
                             $time, want.fail_position, m_axis_tdata[16:1]);
                    err_count++;
                end
            end
        end
    end

    function automatic logic [7:0] pat_byte(input int idx);
        if (idx >= PATTERN_BYTES || idx >= REG_BYTES)
            return 8'h00;
        return pat_words[idx / 8][8 * (idx % 8) +: 8];
    endfunction

    function automatic logic [5:0] step_ptr(input logic [5:0] p);
        return (p < PATTERN_BYTES) ? p + 6'd1 : 6'(PATTERN_BYTES);
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == '1) ? v : v + 16'd1;
    endfunction

    function automatic void note_fail(input logic [15:0] pos);
        if (!pkt_failed) begin
            pkt_failed = 1'b1;
            first_fail_pos = pos;
        end
    endfunction

    function automatic void clear_packet_state();
        pat_ptr = '0;
        run_left = '0;
        run_kind = KIND_NONE;
        byte_count = '0;
        pkt_failed = 1'b0;
        first_fail_pos = '0;
    endfunction

    function automatic void predict_match_byte(input logic [7:0] d, input logic is_last);
        logic [7:0]  cmd;
        logic [15:0] pos;
        t_result     verdict;
        pos = sat_inc(byte_count);
        byte_count = pos;
        if (!pkt_failed && run_left == 0) begin
            cmd = pat_byte(pat_ptr);
            case (cmd[3:0])
                CMD_LITERAL: run_kind = KIND_LITERAL;
                CMD_REPEAT:  run_kind = KIND_REPEAT;
                CMD_SKIP:    run_kind = KIND_SKIP;
                default: begin
                    run_kind = KIND_NONE;
                    note_fail(pos);
                end
            endcase
            if (!pkt_failed) begin
                run_left = {1'b0, cmd[7:4]} + 5'd1;
                pat_ptr = step_ptr(pat_ptr);
            end
        end
        if (!pkt_failed) begin
            if (run_kind == KIND_LITERAL || run_kind == KIND_REPEAT) begin
                if (d != pat_byte(pat_ptr)) begin
                    note_fail(pos);
                end else begin
                    run_left--;
                    if (run_kind == KIND_LITERAL || run_left == 0)
                        pat_ptr = step_ptr(pat_ptr);
                end
            end else begin
                run_left--;
            end
            if (run_left == 0)
                run_kind = KIND_NONE;
        end
        if (is_last) begin
            cmd = pat_byte(pat_ptr);
            if (!pkt_failed && (run_left != 0 || cmd[3:0] != CMD_END))
                note_fail(sat_inc(byte_count));
            verdict.matched = !pkt_failed;
            verdict.fail_position = pkt_failed ? first_fail_pos : '0;
            pending_verdicts.push_back(verdict);
            clear_packet_state();
        end
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic is_last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tlast <= is_last;
        predict_match_byte(d, is_last);
        bytes_sent++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_packet();
        foreach (pkt_bytes[i])
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    // sender pauses until every verdict is back, then lets the pipe settle
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        pat_words[idx] = val;
    endtask

    function automatic logic [63:0] draft_word(input int k);
        logic [63:0] w;
        for (int j = 0; j < 8; j++)
            w[8 * j +: 8] = pat_draft[8 * k + j];
        return w;
    endfunction

    task automatic set_pattern();
        write_reg(CFG_PAT_WORD_0, draft_word(0));
        write_reg(CFG_PAT_WORD_1, draft_word(1));
        write_reg(CFG_PAT_WORD_2, draft_word(2));
        write_reg(CFG_PAT_WORD_3, draft_word(3));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void fill_draft(input logic [7:0] v);
        foreach (pat_draft[i])
            pat_draft[i] = v;
    endfunction

    task automatic gen_pattern();
        int         idx;
        int         cmds;
        int         target;
        int         sel;
        bit         done;
        logic [3:0] n;
        foreach (pat_draft[i])
            pat_draft[i] = 8'($urandom_range(0, 255));
        idx = 0;
        cmds = 0;
        done = 1'b0;
        target = ($urandom_range(0, 9) == 0) ? 99 : $urandom_range(1, 6);
        while (idx < REG_BYTES && !done) begin
            sel = $urandom_range(0, 99);
            n = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 3));
            if (cmds == target) begin
                pat_draft[idx][3:0] = CMD_END;
                done = 1'b1;
            end else if (sel < 5) begin
                pat_draft[idx][3:0] = 4'($urandom_range(CMD_REPEAT + 1, CMD_SKIP - 1));
                done = 1'b1;
            end else if (sel < 45) begin
                pat_draft[idx] = {n, CMD_LITERAL};
                idx = idx + 2 + n;
            end else if (sel < 75) begin
                pat_draft[idx] = {n, CMD_REPEAT};
                idx = idx + 2;
            end else begin
                pat_draft[idx] = {n, CMD_SKIP};
                idx = idx + 1;
            end
            cmds++;
        end
    endtask

    // walk the loaded pattern to get a matching packet, then maybe break it
    task automatic build_packet();
        int         ptr;
        int         n;
        int         k;
        bit         stop;
        logic [7:0] c;
        pkt_bytes.delete();
        ptr = 0;
        stop = 1'b0;
        while (!stop) begin
            c = pat_byte(ptr);
            n = c[7:4] + 1;
            case (c[3:0])
                CMD_LITERAL: begin
                    ptr = step_ptr(ptr);
                    repeat (n) begin
                        pkt_bytes.push_back(pat_byte(ptr));
                        ptr = step_ptr(ptr);
                    end
                end
                CMD_REPEAT: begin
                    ptr = step_ptr(ptr);
                    repeat (n) pkt_bytes.push_back(pat_byte(ptr));
                    ptr = step_ptr(ptr);
                end
                CMD_SKIP: begin
                    ptr = step_ptr(ptr);
                    repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default: stop = 1'b1;
            endcase
        end
        case ($urandom_range(0, 9))
            0: if (pkt_bytes.size() > 0) begin
                k = $urandom_range(0, pkt_bytes.size() - 1);
                pkt_bytes[k] = pkt_bytes[k] ^ 8'($urandom_range(1, 255));
            end
            1: repeat ($urandom_range(1, 3))
                if (pkt_bytes.size() > 0) void'(pkt_bytes.pop_back());
            2: repeat ($urandom_range(1, 3))
                pkt_bytes.push_back(8'($urandom_range(0, 255)));
            3: begin
                pkt_bytes.delete();
                repeat ($urandom_range(1, 8))
                    pkt_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        if (pkt_bytes.size() > MAX_PKT_LEN) begin
            k = $urandom_range(1, MAX_PKT_LEN);
            while (pkt_bytes.size() > k) void'(pkt_bytes.pop_back());
        end
        if (pkt_bytes.size() == 0)
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic test_reset_defaults();
        // all-zero words: the first byte meets an end command
        pkt_bytes = '{8'h00};
        send_packet();
        wait_results();
    endtask

    task automatic test_directed_commands();
        // literal "AB", repeat 'C' x3, skip 2, end
        fill_draft(8'h00);
        pat_draft[0] = {4'd1, CMD_LITERAL};
        pat_draft[1] = 8'h41;
        pat_draft[2] = 8'h42;
        pat_draft[3] = {4'd2, CMD_REPEAT};
        pat_draft[4] = 8'h43;
        pat_draft[5] = {4'd1, CMD_SKIP};
        pat_draft[6] = {4'd0, CMD_END};
        set_pattern();
        pkt_bytes = '{8'h41, 8'h42, 8'h43, 8'h43, 8'h43, 8'h00, 8'hFF};
        send_packet();
        pkt_bytes = '{8'h41, 8'h42, 8'h43, 8'h43, 8'h43, 8'h5A};
        send_packet();
        pkt_bytes = '{8'h41, 8'h58};
        send_packet();
        wait_results();

        // unknown command
        fill_draft(8'h00);
        pat_draft[0] = {4'd0, CMD_REPEAT + 4'd3};
        set_pattern();
        pkt_bytes = '{8'hA5};
        send_packet();
        wait_results();

        // skip running up to the last byte, then one extra byte
        fill_draft(8'h00);
        pat_draft[0] = {4'd2, CMD_SKIP};
        pat_draft[1] = {4'hF, CMD_END};
        set_pattern();
        pkt_bytes = '{8'h00, 8'hFF, 8'h5A};
        send_packet();
        pkt_bytes = '{8'hFF, 8'h00, 8'h3C, 8'hC3};
        send_packet();
        wait_results();
    endtask

    task automatic test_output_stall();
        fork
            begin
                rx_hold_req <= 1'b1;
                repeat (80) @(posedge i_clk);
                rx_hold_req <= 1'b0;
            end
            begin
                repeat (6) begin
                    pkt_bytes.delete();
                    repeat (3) pkt_bytes.push_back(8'($urandom_range(0, 255)));
                    send_packet();
                end
            end
        join
        wait_results();
    endtask

    task automatic test_random_packets(input int n_items);
        int start;
        int cfg_no;
        start = bytes_sent;
        cfg_no = 0;
        while (bytes_sent - start < n_items) begin
            wait_results();
            if (cfg_no == 0)
                fill_draft(8'hFF);
            else if (cfg_no == 1)
                fill_draft(8'h00);
            else
                gen_pattern();
            set_pattern();
            repeat ($urandom_range(2, 6)) begin
                build_packet();
                send_packet();
            end
            cfg_no++;
        end
        wait_results();
    endtask

    task automatic test_no_idle_stream();
        idle_on <= 1'b0;
        test_random_packets(60);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_PAT_WORD_0;
        i_cfg_data <= '0;
        foreach (pat_words[i])
            pat_words[i] = '0;
        clear_packet_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_commands();
        test_output_stall();
        test_random_packets(340);
        test_no_idle_stream();

        repeat (10) @(posedge i_clk);
        if (err_count == 0 && pending_verdicts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
